### design/mia_pkg.sv
// Shared constants and word types for the matrix inverse adjugate unit.
package mia_pkg;

	localparam int MIA_MAX_SIZE = 4;
	localparam int LIMB_W = 32;
	localparam int LIMBS = 8;
	localparam int LIMB_AW = 3;
	localparam int WIDE_W = LIMB_W * LIMBS;
	localparam logic [2:0] SIZE_RESET = 3'd2;

	typedef struct packed {
		logic signed [31:0] element;
	} elem_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0] out_row;
		logic [1:0] out_col;
		logic singular;
		logic last;
	} result_word_t;

endpackage

### design/mia_stream_if.sv
// Valid/ready stream channel that carries one word per handshake.
interface mia_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/mia_div.sv
// Restoring divider, one quotient bit per cycle, with signed saturation to 32 bits.
module mia_div
	import mia_pkg::*;
#(
	parameter int WIDE = WIDE_W
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic neg,
	input logic [WIDE-1:0] num,
	input logic [WIDE-1:0] den,
	output logic done,
	output logic [31:0] quo
);

	localparam int CNW = $clog2(WIDE);

	logic busy_q;
	logic done_q;
	logic [CNW-1:0] cnt_q;
	logic [WIDE-1:0] num_q;
	logic [WIDE-1:0] den_q;
	logic [WIDE-1:0] rem_q;
	logic [31:0] q_q;
	logic ovf_q;
	logic neg_q;

	logic [WIDE:0] rem_n;
	logic [WIDE+1:0] diff;
	logic ge;
	logic [31:0] lim;

	assign rem_n = {rem_q, num_q[WIDE-1]};
	assign diff = {1'b0, rem_n} - {2'b00, den_q};
	assign ge = !diff[WIDE+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNW'(WIDE - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= neg;
			cnt_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[WIDE-1:0] : rem_n[WIDE-1:0];
			q_q <= {q_q[30:0], ge};
			ovf_q <= ovf_q | q_q[31];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		lim = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
		if (ovf_q || q_q > lim) begin
			quo = lim;
		end else begin
			quo = neg_q ? (32'd0 - q_q) : q_q;
		end
	end

	assign done = done_q;

endmodule

### design/matrix_inverse_adjugate_unit.sv
// Matrix inverse by adjugate: loads an n-by-n Q16.16 matrix one word per handshake in
// row-major order, then returns the n*n inverse words in row-major order, each the
// adjugate element over the determinant, truncated toward zero and saturated to Q16.16.
// A zero determinant returns one word with the singular flag set. The input accepts a
// word each cycle while loading and is not ready from the last element until the final
// result word is taken. All arithmetic is exact on 256-bit integers. Every determinant
// and minor is built by a cofactor recursion over column subsets, stored limb by limb in
// a subset table, and each cofactor term is one pass of a single 33x33-bit limb
// multiply-accumulate over eight limbs, with a scan step for each column that is skipped.
// Each inverse element then costs a minor, a restoring division and a fetch and
// handoff. A size write on cfg_we restarts the load; a size of 0 acts as 1 and one above
// MAX_SIZE acts as MAX_SIZE.
module matrix_inverse_adjugate_unit
	import mia_pkg::*;
#(
	parameter int MAX_SIZE = MIA_MAX_SIZE
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_wdata,
	mia_stream_if.sink in_ch,
	mia_stream_if.source out_ch
);

	localparam int IW = $clog2(MAX_SIZE + 1);
	localparam int CW = $clog2(MAX_SIZE * MAX_SIZE + 1);
	localparam int SD = MAX_SIZE * MAX_SIZE;
	localparam int AW = (SD > 1) ? $clog2(SD) : 1;
	localparam int TD = (1 << MAX_SIZE) * LIMBS;
	localparam int TAW = MAX_SIZE + LIMB_AW;
	localparam int LCW = LIMB_AW + 1;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_MAC   = 7'b0000100,
		ST_FETCH = 7'b0001000,
		ST_EVAL  = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_SEND  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [2:0] size_q;
	logic [CW-1:0] cnt_q;

	// Matrix store and subset determinant table.
	logic [31:0] mem [SD];
	logic [31:0] tab [TD];
	logic signed [31:0] elem_q;
	logic [31:0] tab_rd_q;

	// Cofactor recursion sequencer.
	logic [MAX_SIZE-1:0] set_q;
	logic [IW-1:0] col_q;
	logic par_q;
	logic first_q;
	logic last_q;
	logic prev_empty_q;
	logic [LCW-1:0] limb_q;
	logic [31:0] acc_q [LIMBS];
	logic signed [33:0] carry_q;
	logic [IW-1:0] m_q;
	logic [IW-1:0] skr_q;
	logic [IW-1:0] skc_q;
	logic det_ph_q;
	logic [IW-1:0] ar_q;
	logic [IW-1:0] ac_q;

	logic [WIDE_W-1:0] wide_q;
	logic [WIDE_W-1:0] det_q;
	logic dneg_q;

	result_word_t out_q;
	logic out_valid_q;

	// Derived size.
	logic [IW-1:0] n_eff;
	logic [CW-1:0] nn;
	logic [MAX_SIZE:0] one_sh;
	logic [MAX_SIZE-1:0] all_m;

	// Element addressing for the current term.
	logic [IW-1:0] pc;
	logic [IW-1:0] lr;
	logic [IW-1:0] row;
	logic [IW-1:0] colx;
	logic [AW-1:0] srd_addr;
	logic [MAX_SIZE-1:0] cmask;
	logic [MAX_SIZE-1:0] prev_set;
	logic bit_c;
	logic last_term;

	// Limb multiply-accumulate.
	logic [LIMB_AW-1:0] limb_m;
	logic [31:0] d_limb;
	logic signed [32:0] e_eff;
	logic signed [65:0] prod;
	logic signed [65:0] sum;

	logic tab_re;
	logic [TAW-1:0] tab_raddr;
	logic [31:0] fetch_limb;

	logic wneg;
	logic [WIDE_W-1:0] wabs;
	logic [IW-1:0] ac_next;
	logic [IW-1:0] ar_next;
	logic in_fire;
	logic out_fire;
	logic run_last;

	logic div_start;
	logic div_done;
	logic [31:0] div_quo;

	always_comb begin
		if (size_q == 3'd0) begin
			n_eff = IW'(1);
		end else if (32'(size_q) > MAX_SIZE) begin
			n_eff = IW'(MAX_SIZE);
		end else begin
			n_eff = IW'(size_q);
		end
	end

	assign nn = CW'(n_eff) * CW'(n_eff);
	assign one_sh = (MAX_SIZE + 1)'(1) << m_q;
	assign all_m = MAX_SIZE'(one_sh - 1'b1);

	// The subset size tells which row of the minor is expanded; skipped rows and
	// columns of the full matrix are stepped over.
	assign pc = IW'($countones(set_q));
	assign lr = m_q - pc;
	assign row = lr + ((lr >= skr_q) ? IW'(1) : IW'(0));
	assign colx = col_q + ((col_q >= skc_q) ? IW'(1) : IW'(0));
	assign srd_addr = AW'(CW'(row) * CW'(n_eff) + CW'(colx));
	assign cmask = MAX_SIZE'(1) << col_q;
	assign prev_set = set_q & ~cmask;
	assign bit_c = |(set_q & cmask);
	assign last_term = ((set_q >> col_q) >> 1) == '0;

	assign limb_m = LIMB_AW'(limb_q - 1'b1);
	assign d_limb = prev_empty_q ? ((limb_m == '0) ? 32'd1 : 32'd0) : tab_rd_q;
	assign e_eff = par_q ? -{elem_q[31], elem_q} : {elem_q[31], elem_q};
	assign prod = $signed({1'b0, d_limb}) * e_eff;
	assign sum = prod + (first_q ? 66'sd0 : $signed({34'd0, acc_q[limb_m]}))
		+ {{32{carry_q[33]}}, carry_q};

	assign tab_re = (state_q == ST_MAC || state_q == ST_FETCH) && limb_q < LCW'(LIMBS);
	assign tab_raddr = (state_q == ST_FETCH)
		? {all_m, LIMB_AW'(LIMBS - 1) - LIMB_AW'(limb_q)}
		: {prev_set, LIMB_AW'(limb_q)};
	assign fetch_limb = (all_m == '0) ? ((limb_q == LCW'(LIMBS)) ? 32'd1 : 32'd0) : tab_rd_q;

	assign wneg = wide_q[WIDE_W-1];
	assign wabs = wneg ? (WIDE_W'(0) - wide_q) : wide_q;
	assign ac_next = (ac_q == n_eff - 1'b1) ? '0 : ac_q + 1'b1;
	assign ar_next = (ac_q == n_eff - 1'b1) ? ar_q + 1'b1 : ar_q;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_valid_q && out_ch.ready;
	assign run_last = out_q.singular || out_q.last;
	assign div_start = (state_q == ST_EVAL) && !det_ph_q;

	assign in_ch.ready = (state_q == ST_LOAD);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mem[cnt_q[AW-1:0]] <= in_ch.data.element;
		end
		if (state_q == ST_SCAN) begin
			elem_q <= mem[srd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MAC && limb_q != '0 && last_q) begin
			tab[{set_q, limb_m}] <= sum[31:0];
		end
		if (tab_re) begin
			tab_rd_q <= tab[tab_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			size_q <= SIZE_RESET;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
				cnt_q <= '0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire && !cfg_we) begin
						if (cnt_q + 1'b1 >= nn) begin
							cnt_q <= '0;
							state_q <= (n_eff == '0) ? ST_FETCH : ST_SCAN;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (bit_c) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (limb_q == LCW'(LIMBS)) begin
						state_q <= (last_q && set_q == all_m) ? ST_FETCH : ST_SCAN;
					end
				end
				ST_FETCH: begin
					if (limb_q == LCW'(LIMBS)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (det_ph_q) begin
						if (wide_q == '0) begin
							out_valid_q <= 1'b1;
							state_q <= ST_SEND;
						end else begin
							state_q <= (n_eff == IW'(1)) ? ST_FETCH : ST_SCAN;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (out_fire) begin
						out_valid_q <= 1'b0;
						if (run_last) begin
							state_q <= ST_LOAD;
						end else begin
							state_q <= (n_eff == IW'(1)) ? ST_FETCH : ST_SCAN;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Datapath registers of the sequencer; a new minor restarts at the smallest subset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				det_ph_q <= 1'b1;
				m_q <= n_eff;
				skr_q <= IW'(MAX_SIZE);
				skc_q <= IW'(MAX_SIZE);
				set_q <= (n_eff == '0) ? '0 : MAX_SIZE'(1);
				col_q <= '0;
				par_q <= 1'b0;
				first_q <= 1'b1;
				limb_q <= '0;
			end
			ST_SCAN: begin
				if (bit_c) begin
					prev_empty_q <= (prev_set == '0);
					last_q <= last_term;
					limb_q <= '0;
					carry_q <= '0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			ST_MAC: begin
				if (limb_q != '0) begin
					acc_q[limb_m] <= sum[31:0];
					carry_q <= sum[65:32];
				end
				if (limb_q == LCW'(LIMBS)) begin
					limb_q <= '0;
					if (last_q) begin
						set_q <= set_q + 1'b1;
						col_q <= '0;
						par_q <= 1'b0;
						first_q <= 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
						par_q <= ~par_q;
						first_q <= 1'b0;
					end
				end else begin
					limb_q <= limb_q + 1'b1;
				end
			end
			ST_FETCH: begin
				if (limb_q != '0) begin
					wide_q <= {wide_q[WIDE_W-LIMB_W-1:0], fetch_limb};
				end
				limb_q <= (limb_q == LCW'(LIMBS)) ? '0 : limb_q + 1'b1;
			end
			ST_EVAL: begin
				if (det_ph_q) begin
					out_q.value <= '0;
					out_q.out_row <= '0;
					out_q.out_col <= '0;
					out_q.singular <= 1'b1;
					out_q.last <= 1'b1;
					det_q <= wabs;
					dneg_q <= wneg;
					det_ph_q <= 1'b0;
					ar_q <= '0;
					ac_q <= '0;
					m_q <= n_eff - 1'b1;
					skr_q <= '0;
					skc_q <= '0;
					set_q <= (n_eff == IW'(1)) ? '0 : MAX_SIZE'(1);
					col_q <= '0;
					par_q <= 1'b0;
					first_q <= 1'b1;
					limb_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					out_q.value <= div_quo;
					out_q.out_row <= 2'(ar_q);
					out_q.out_col <= 2'(ac_q);
					out_q.singular <= 1'b0;
					out_q.last <= (ar_q == n_eff - 1'b1) && (ac_q == n_eff - 1'b1);
				end
			end
			ST_SEND: begin
				if (out_fire && !run_last) begin
					ac_q <= ac_next;
					ar_q <= ar_next;
					skr_q <= ac_next;
					skc_q <= ar_next;
					set_q <= (n_eff == IW'(1)) ? '0 : MAX_SIZE'(1);
					col_q <= '0;
					par_q <= 1'b0;
					first_q <= 1'b1;
					limb_q <= '0;
				end
			end
			default: begin
				limb_q <= '0;
			end
		endcase
	end

	mia_div #(
		.WIDE(WIDE_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.neg(wneg ^ dneg_q ^ ar_q[0] ^ ac_q[0]),
		.num(wabs << LIMB_W),
		.den(det_q),
		.done(div_done),
		.quo(div_quo)
	);

endmodule

### test/tb_matrix_inverse_adjugate_unit.sv
// Testbench for matrix_inverse_adjugate_unit: directed table, then random matrices.
module tb_matrix_inverse_adjugate_unit;
	import mia_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 3000;
	localparam int NO_CFG = -1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_wdata;

	mia_stream_if #(.T(elem_word_t)) elem_ch ();
	mia_stream_if #(.T(result_word_t)) inv_ch ();

	matrix_inverse_adjugate_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(elem_ch),
		.out_ch(inv_ch)
	);

	// One row of the directed table. When known is set, the row completes a matrix
	// whose single result is typed in here instead of coming from the predictor.
	typedef struct {
		int size;
		logic [31:0] elem;
		bit known;
		logic [31:0] val;
		bit sing;
	} dir_row_t;

	// Predictor state: its own copy of the size register and the matrix being loaded.
	logic signed [31:0] mat_shadow [16];
	int load_pos;
	logic [2:0] size_shadow;
	int active_n;

	result_word_t inverse_q[$];
	int fail_count;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Determinant of the submatrix picked by a row mask and a column mask, expanded
	// along its first remaining row. Exact on 256 bits for every size in use.
	function automatic logic signed [255:0] sub_det(int rows, int cols);
		logic signed [255:0] acc;
		logic signed [255:0] term;
		int r;
		int pos;
		if (rows == 0) begin
			return 256'sd1;
		end
		r = 0;
		while (((rows >> r) & 1) == 0) begin
			r++;
		end
		acc = '0;
		pos = 0;
		for (int c = 0; c < active_n; c++) begin
			if (((cols >> c) & 1) != 0) begin
				term = sub_det(rows & ~(1 << r), cols & ~(1 << c)) * mat_shadow[r * active_n + c];
				if (pos % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
				pos++;
			end
		end
		return acc;
	endfunction

	// Adjugate element over the determinant in Q16.16, truncated toward zero and saturated.
	function automatic logic [31:0] q16_quotient(logic signed [255:0] num,
			logic signed [255:0] den);
		logic signed [255:0] q;
		q = (num <<< 32) / den;
		if (q > $signed(256'd2147483647)) begin
			return 32'h7FFF_FFFF;
		end
		if (q < -$signed(256'd2147483648)) begin
			return 32'h8000_0000;
		end
		return q[31:0];
	endfunction

	// Takes one accepted element and queues the inverse words that it completes.
	task automatic predict_inverse(logic [31:0] elem);
		int n;
		int all;
		logic signed [255:0] det;
		logic signed [255:0] adj;
		result_word_t w;
		n = (size_shadow == 0) ? 1 : ((size_shadow > MIA_MAX_SIZE) ? MIA_MAX_SIZE : size_shadow);
		if (load_pos < 16) begin
			mat_shadow[load_pos] = elem;
		end
		load_pos++;
		if (load_pos < n * n) begin
			return;
		end
		load_pos = 0;
		active_n = n;
		all = (1 << n) - 1;
		det = sub_det(all, all);
		if (det == 0) begin
			w = '{value: '0, out_row: '0, out_col: '0, singular: 1'b1, last: 1'b1};
			inverse_q.push_back(w);
			return;
		end
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				// The inverse at (r,c) takes the cofactor of (c,r): transposed position.
				adj = sub_det(all & ~(1 << c), all & ~(1 << r));
				if ((r + c) % 2 == 1) begin
					adj = -adj;
				end
				w.value = q16_quotient(adj, det);
				w.out_row = r[1:0];
				w.out_col = c[1:0];
				w.singular = 1'b0;
				w.last = (r == n - 1 && c == n - 1);
				inverse_q.push_back(w);
			end
		end
	endtask

	// Size writes happen only while the unit is idle, so withdraw the offered word, wait
	// for every expected word and then a short settle before driving the write at a
	// falling edge. Called on a falling edge.
	task automatic write_size(int size);
		elem_ch.valid <= 1'b0;
		wait (inverse_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= size[2:0];
		@(posedge clk);
		size_shadow = size[2:0];
		load_pos = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one word, with random idle cycles in front of it, and returns at a falling
	// edge once the word has been taken and given to the predictor. Called on a falling edge or just after one.
	task automatic send_elem(logic [31:0] elem);
		while ($urandom_range(99) < send_idle_pct) begin
			elem_ch.valid <= 1'b0;
			@(negedge clk);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.data <= elem;
		do begin
			@(posedge clk);
		end while (!elem_ch.ready);
		predict_inverse(elem);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_elem(int style);
		case (style)
			0: return $urandom();
			1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			default: return ($urandom_range(3) == 0) ? 32'h0 : ($urandom_range(7) - 3) << 16;
		endcase
	endfunction

	// Receiver: random stalls at falling edges, plus one long hold-off on request while
	// the sender keeps offering words, so the unit holds its result and stalls its input.
	initial begin
		int hold_left;
		hold_left = 0;
		inv_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				inv_ch.ready <= 1'b0;
			end else begin
				inv_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Checker: compares each accepted inverse word with the oldest expectation.
	always @(posedge clk) begin
		result_word_t exp_w;
		if (arst_n && inv_ch.valid && inv_ch.ready) begin
			if (inverse_q.size() == 0) begin
				$error("unexpected inverse word %h", inv_ch.data);
				fail_count++;
			end else begin
				exp_w = inverse_q.pop_front();
				if (inv_ch.data.value !== exp_w.value) begin
					$error("value: expected %h, got %h", exp_w.value, inv_ch.data.value);
					fail_count++;
				end
				if (inv_ch.data.out_row !== exp_w.out_row) begin
					$error("out_row: expected %0d, got %0d", exp_w.out_row, inv_ch.data.out_row);
					fail_count++;
				end
				if (inv_ch.data.out_col !== exp_w.out_col) begin
					$error("out_col: expected %0d, got %0d", exp_w.out_col, inv_ch.data.out_col);
					fail_count++;
				end
				if (inv_ch.data.singular !== exp_w.singular) begin
					$error("singular: expected %b, got %b", exp_w.singular, inv_ch.data.singular);
					fail_count++;
				end
				if (inv_ch.data.last !== exp_w.last) begin
					$error("last: expected %b, got %b", exp_w.last, inv_ch.data.last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a 4x4 matrix is slow to invert, so the limit is generous.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_matrix_inverse_adjugate_unit failed");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_rows[$];
		logic [31:0] mtx [16];
		int sizes [10];
		int n;
		int cnt;
		int style;
		int sent;
		bit force_cfg;
		result_word_t w;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		elem_ch.valid = 1'b0;
		elem_ch.data = '0;
		hold_req = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_pos = 0;
		size_shadow = SIZE_RESET;
		active_n = 1;

		// Directed table. A 1x1 inverse is 2^32 over the raw element, so tiny and
		// extreme elements saturate or give small whole numbers.
		dir_rows = '{
			'{1, 32'h0000_0000, 1, 32'h0000_0000, 1},
			'{NO_CFG, 32'h0000_0001, 1, 32'h7FFF_FFFF, 0},
			'{NO_CFG, 32'hFFFF_FFFF, 1, 32'h8000_0000, 0},
			'{NO_CFG, 32'h7FFF_FFFF, 1, 32'h0000_0002, 0},
			'{NO_CFG, 32'h8000_0000, 1, 32'hFFFF_FFFE, 0},
			'{NO_CFG, 32'h0001_0000, 1, 32'h0001_0000, 0},
			'{0, 32'h0001_0000, 1, 32'h0001_0000, 0},
			'{2, 32'h0001_0000, 0, 0, 0},
			'{NO_CFG, 32'h0000_0000, 0, 0, 0},
			'{NO_CFG, 32'h0000_0000, 0, 0, 0},
			'{NO_CFG, 32'h0001_0000, 0, 0, 0},
			'{NO_CFG, 32'h7FFF_FFFF, 0, 0, 0},
			'{NO_CFG, 32'h8000_0000, 0, 0, 0},
			'{NO_CFG, 32'h8000_0000, 0, 0, 0},
			'{NO_CFG, 32'h7FFF_FFFF, 0, 0, 0},
			'{NO_CFG, 32'h0000_0000, 0, 0, 0},
			'{NO_CFG, 32'h0000_0000, 0, 0, 0},
			'{NO_CFG, 32'h0000_0000, 0, 0, 0},
			'{NO_CFG, 32'h0000_0000, 1, 32'h0000_0000, 1}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].size != NO_CFG) begin
				write_size(dir_rows[i].size);
			end
			send_elem(dir_rows[i].elem);
			if (dir_rows[i].known) begin
				// The predictor has queued this row's result; the typed value replaces it.
				void'(inverse_q.pop_back());
				w = '{value: dir_rows[i].val, out_row: '0, out_col: '0,
					singular: dir_rows[i].sing, last: 1'b1};
				inverse_q.push_back(w);
			end
		end

		// Random part in three idling phases. Sizes lean small; 0, 5 and 7 test clamping.
		sizes = '{1, 2, 2, 3, 3, 4, 0, 5, 7, 2};
		force_cfg = 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 19 : ((phase == 1) ? 46 : 0);
			recv_idle_pct = (phase == 0) ? 46 : ((phase == 1) ? 19 : 0);
			if (phase == 2) begin
				hold_req = 1'b1;
			end
			sent = 0;
			while (sent < 27) begin
				if (force_cfg || $urandom_range(99) < 60) begin
					write_size(sizes[$urandom_range(9)]);
					force_cfg = 1'b0;
				end
				n = (size_shadow == 0) ? 1 :
					((size_shadow > MIA_MAX_SIZE) ? MIA_MAX_SIZE : size_shadow);
				style = $urandom_range(3);
				foreach (mtx[k]) begin
					mtx[k] = rand_elem(style == 3 ? 0 : style);
				end
				// Copying the first row into the second gives a singular matrix.
				if (style == 3 && n >= 2) begin
					for (int c = 0; c < n; c++) begin
						mtx[n + c] = mtx[c];
					end
				end
				cnt = n * n;
				// Now and then leave a load unfinished; the next size write discards it.
				if (cnt > 1 && $urandom_range(9) == 0) begin
					cnt = $urandom_range(cnt - 1, 1);
					force_cfg = 1'b1;
				end
				for (int k = 0; k < cnt; k++) begin
					send_elem(mtx[k]);
					sent++;
				end
			end
		end
		elem_ch.valid <= 1'b0;

		wait (inverse_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_matrix_inverse_adjugate_unit passed");
		end else begin
			$display("tb_matrix_inverse_adjugate_unit failed");
		end
		$finish;
	end

endmodule
